// ===== hw/rtl/bpfl_pkg.sv =====
// Shared types and constants for the block pool free-list allocator.
// Used by the controller, the datapath, the top level and the checker.
package bpfl_pkg;

    localparam int POOL_BLOCKS = 1024;
    localparam int NUM_DEVICES = 16;
    localparam int MAX_MOVES   = 16;

    localparam int BLK_W     = $clog2(POOL_BLOCKS);
    localparam int CNT_W     = BLK_W + 1;
    localparam int DEV_IDX_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

    localparam int KIND_W  = 2;
    localparam int DEV_W   = 4;
    localparam int BCNT_W  = 5;
    localparam int SLOT_W  = 10;
    localparam int ADDR_W  = 48;
    localparam int FREE_W  = 11;
    localparam int BSL_W   = 6;
    localparam int GRAN_W  = 2;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [KIND_W-1:0] KIND_INIT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    localparam logic REG_BLOCK_SIZE  = 1'b0;
    localparam logic REG_GRANULARITY = 1'b1;

    localparam logic [BSL_W-1:0]  BSL_RESET  = 6'd28;
    localparam logic [GRAN_W-1:0] GRAN_RESET = 2'd0;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [DEV_W-1:0]  device_id;
        logic [BCNT_W-1:0] block_count;
    } t_in_item;

    typedef struct packed {
        logic              status;
        logic [DEV_W-1:0]  device_id_res;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] block_addr;
        logic [FREE_W-1:0] free_count;
        logic              last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INIT,
        S_READ,
        S_MOVE,
        S_END_OK,
        S_END_ERR
    } t_state;

    typedef struct packed {
        logic load;
        logic init_start;
        logic sweep;
        logic rd;
        logic move;
        logic emit_end;
        logic err;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_init;
        logic is_bad;
        logic count_zero;
        logic src_empty;
        logic sweep_done;
        logic last_move;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/bpfl_ctrl.sv =====
// Controller state machine of the allocator: sequences decode, init sweep
// and the per-block read/move steps. Depends on bpfl_pkg.
module bpfl_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  bpfl_pkg::t_dp_status i_status,
    output bpfl_pkg::t_ctrl_cmd  o_cmd
);
    import bpfl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_status.is_init) begin
                    o_cmd.init_start = 1'b1;
                    n_state          = S_INIT;
                end else if (i_status.is_bad) begin
                    n_state = S_END_ERR;
                end else if (i_status.count_zero) begin
                    n_state = S_END_OK;
                end else begin
                    n_state = S_READ;
                end
            end
            S_INIT: begin
                o_cmd.sweep = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_END_OK;
                end
            end
            S_READ: begin
                // source ran dry: close the item with an error result
                if (i_status.src_empty) begin
                    n_state = S_END_ERR;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_MOVE;
                end
            end
            S_MOVE: begin
                if (i_status.out_free) begin
                    o_cmd.move = 1'b1;
                    n_state    = i_status.last_move ? S_IDLE : S_READ;
                end
            end
            S_END_OK, S_END_ERR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    o_cmd.err      = (r_state == S_END_ERR);
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bpfl_datapath.sv =====
// Datapath of the allocator: list heads/tails/totals, the link memory,
// the item registers and the output register. Depends on bpfl_pkg.
module bpfl_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  bpfl_pkg::t_in_item               i_in,
    input  bpfl_pkg::t_ctrl_cmd              i_cmd,
    input  logic [bpfl_pkg::BSL_W-1:0]       i_block_size_log2,
    input  logic [bpfl_pkg::GRAN_W-1:0]      i_granularity_log2,
    input  logic                             i_out_stall,
    output bpfl_pkg::t_dp_status             o_status,
    output logic                             o_out_valid,
    output bpfl_pkg::t_out_item              o_out
);
    import bpfl_pkg::*;

    // item registers
    logic [KIND_W-1:0] r_kind;
    logic [DEV_W-1:0]  r_dev;
    logic [BCNT_W-1:0] r_count;
    logic [BCNT_W-1:0] r_moved;
    logic [BLK_W-1:0]  r_sweep;

    // list state
    logic [BLK_W-1:0] r_free_head;
    logic [BLK_W-1:0] r_free_tail;
    logic [CNT_W-1:0] r_free_total;
    logic [BLK_W-1:0] r_dev_head  [NUM_DEVICES];
    logic [BLK_W-1:0] r_dev_tail  [NUM_DEVICES];
    logic [CNT_W-1:0] r_dev_total [NUM_DEVICES];

    // link memory, contents undefined until written
    logic [BLK_W-1:0] r_link [POOL_BLOCKS];
    logic [BLK_W-1:0] r_link_rd;

    logic      r_out_valid;
    t_out_item r_out;

    logic [DEV_IDX_W-1:0] dix;
    logic [CNT_W-1:0]     pool_n;
    logic                 is_alloc;
    logic [BLK_W-1:0]     cur_dev_head;
    logic [BLK_W-1:0]     cur_dev_tail;
    logic [CNT_W-1:0]     cur_dev_total;
    logic [BLK_W-1:0]     blk;
    logic [BCNT_W-1:0]    in_cnt;
    logic [63:0]          shifted;
    logic                 out_free;

    logic [CNT_W-1:0]  n_free_total;
    logic [CNT_W-1:0]  n_dev_total;
    logic [SLOT_W-1:0] n_slot;

    logic             mem_we;
    logic [BLK_W-1:0] mem_waddr;
    logic [BLK_W-1:0] mem_wdata;

    always_comb begin
        dix           = DEV_IDX_W'(r_dev);
        pool_n        = CNT_W'(POOL_BLOCKS >> i_granularity_log2);
        is_alloc      = (r_kind == KIND_ALLOC);
        cur_dev_head  = r_dev_head[dix];
        cur_dev_tail  = r_dev_tail[dix];
        cur_dev_total = r_dev_total[dix];
        blk           = is_alloc ? r_free_head : cur_dev_head;
        in_cnt        = (i_in.block_count > BCNT_W'(MAX_MOVES)) ?
                        BCNT_W'(MAX_MOVES) : i_in.block_count;
        shifted       = 64'(blk) << i_block_size_log2;
        out_free      = !r_out_valid || !i_out_stall;

        if (is_alloc) begin
            n_free_total = r_free_total - CNT_W'(1);
            n_dev_total  = cur_dev_total + CNT_W'(1);
            n_slot       = SLOT_W'(cur_dev_total);
        end else begin
            n_free_total = r_free_total + CNT_W'(1);
            n_dev_total  = cur_dev_total - CNT_W'(1);
            n_slot       = SLOT_W'(n_dev_total);
        end

        o_status.is_init    = (r_kind == KIND_INIT);
        o_status.is_bad     = ((r_kind != KIND_ALLOC) && (r_kind != KIND_RELEASE)) ||
                              (32'(r_dev) >= NUM_DEVICES);
        o_status.count_zero = (r_count == '0);
        o_status.src_empty  = is_alloc ? (r_free_total == '0) : (cur_dev_total == '0);
        o_status.sweep_done = (CNT_W'(r_sweep) + CNT_W'(1)) >= pool_n;
        o_status.last_move  = ((r_moved + BCNT_W'(1)) == r_count);
        o_status.out_free   = out_free;

        mem_we    = 1'b0;
        mem_waddr = r_sweep;
        mem_wdata = r_sweep + BLK_W'(1);
        if (i_cmd.sweep) begin
            mem_we = !o_status.sweep_done;
        end else if (i_cmd.move) begin
            // link the moved block behind the current tail of the target list
            if (is_alloc) begin
                mem_we    = (cur_dev_total != '0);
                mem_waddr = cur_dev_tail;
            end else begin
                mem_we    = (r_free_total != '0);
                mem_waddr = r_free_tail;
            end
            mem_wdata = blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd) begin
            r_link_rd <= r_link[blk];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_in.kind;
            r_dev   <= i_in.device_id;
            r_count <= in_cnt;
        end
        if (i_cmd.move || i_cmd.emit_end) begin
            r_out.device_id_res <= o_status.is_init ? '0 : r_dev;
            r_out.last          <= i_cmd.emit_end || o_status.last_move;
        end
        if (i_cmd.move) begin
            r_out.status     <= ST_OK;
            r_out.slot       <= n_slot;
            r_out.block_addr <= shifted[ADDR_W-1:0];
            r_out.free_count <= FREE_W'(n_free_total);
        end
        if (i_cmd.emit_end) begin
            r_out.status     <= i_cmd.err ? ST_ERR : ST_OK;
            r_out.slot       <= '0;
            r_out.block_addr <= '0;
            r_out.free_count <= FREE_W'(r_free_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moved      <= '0;
            r_sweep      <= '0;
            r_free_head  <= '0;
            r_free_tail  <= '0;
            r_free_total <= '0;
            r_out_valid  <= 1'b0;
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_dev_head[d]  <= '0;
                r_dev_tail[d]  <= '0;
                r_dev_total[d] <= '0;
            end
        end else begin
            if (i_cmd.move || i_cmd.emit_end) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.load) begin
                r_moved <= '0;
            end else if (i_cmd.move) begin
                r_moved <= r_moved + BCNT_W'(1);
            end

            if (i_cmd.init_start) begin
                r_sweep      <= '0;
                r_free_head  <= '0;
                r_free_tail  <= BLK_W'(pool_n - CNT_W'(1));
                r_free_total <= pool_n;
                for (int d = 0; d < NUM_DEVICES; d++) begin
                    r_dev_head[d]  <= '0;
                    r_dev_tail[d]  <= '0;
                    r_dev_total[d] <= '0;
                end
            end else if (i_cmd.sweep && !o_status.sweep_done) begin
                r_sweep <= r_sweep + BLK_W'(1);
            end

            if (i_cmd.move) begin
                r_free_total     <= n_free_total;
                r_dev_total[dix] <= n_dev_total;
                if (is_alloc) begin
                    // pop the free head, append to the device tail
                    if (n_free_total != '0) begin
                        r_free_head <= r_link_rd;
                    end
                    if (cur_dev_total == '0) begin
                        r_dev_head[dix] <= blk;
                    end
                    r_dev_tail[dix] <= blk;
                end else begin
                    // pop the device head, append to the free tail
                    if (n_dev_total != '0) begin
                        r_dev_head[dix] <= r_link_rd;
                    end
                    if (r_free_total == '0) begin
                        r_free_head <= blk;
                    end
                    r_free_tail <= blk;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== hw/rtl/block_pool_free_list_allocator.sv =====
// Block pool free-list allocator, top level: configuration registers and
// the controller/datapath pair. Depends on bpfl_pkg, bpfl_ctrl, bpfl_datapath.
// Allocate/release: decode, then for each block moved a link memory read and
// then the list update; a bad item, a zero count or a source that runs dry,
// also mid-item, closes the item with an end result. Init sweeps the pool with
// one link memory write per block but the last. One item at a time; the input
// is taken again once the last result sits in the output register. Output
// stalls hold the move and end steps.
// Reset (synchronous): all lists empty, configuration registers to defaults; the link
// memory is not cleared, and the pool holds no blocks until an init item.
module block_pool_free_list_allocator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  bpfl_pkg::t_in_item                i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output bpfl_pkg::t_out_item               o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bpfl_pkg::PADDR_W-1:0]      paddr,
    input  logic [bpfl_pkg::PDATA_W-1:0]      pwdata,
    output logic [bpfl_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import bpfl_pkg::*;

    logic [BSL_W-1:0]  r_block_size_log2;
    logic [GRAN_W-1:0] r_granularity_log2;
    logic              reg_idx;
    logic              cfg_wr;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size_log2  <= BSL_RESET;
            r_granularity_log2 <= GRAN_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_BLOCK_SIZE:  r_block_size_log2  <= pwdata[BSL_W-1:0];
                REG_GRANULARITY: r_granularity_log2 <= pwdata[GRAN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_BLOCK_SIZE:  prdata = PDATA_W'(r_block_size_log2);
            REG_GRANULARITY: prdata = PDATA_W'(r_granularity_log2);
            default:         prdata = '0;
        endcase
    end

    bpfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bpfl_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in               (i_in),
        .i_cmd              (cmd),
        .i_block_size_log2  (r_block_size_log2),
        .i_granularity_log2 (r_granularity_log2),
        .i_out_stall        (i_out_stall),
        .o_status           (status),
        .o_out_valid        (o_out_valid),
        .o_out              (o_out)
    );

endmodule

// ===== hw/rtl/bpfl_checker.sv =====
// Port-level checks for the block pool free-list allocator, bound to the
// top level below. Depends on bpfl_pkg.
module bpfl_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              o_out_valid,
    input  logic                              i_out_stall,
    input  bpfl_pkg::t_out_item               o_out
);
    import bpfl_pkg::*;

    // a result held under stall keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // an error always closes the item
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_ERR) |-> o_out.last)
        else $error("error result not marked last");

    // an error result carries no block
    a_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_ERR) |->
            (o_out.slot == '0) && (o_out.block_addr == '0))
        else $error("error result carries a block");

    // free list never holds more than the pool
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out.free_count) <= POOL_BLOCKS))
        else $error("free count above pool size");

    // reset drops any pending result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind block_pool_free_list_allocator bpfl_checker u_bpfl_checker (.*);

// ===== test/block_pool_free_list_allocator_tb.sv =====
// Self-checking testbench for block_pool_free_list_allocator: drives request
// items with random gaps and stalls, predicts every block move and checks it.
// Depends on bpfl_pkg and the block_pool_free_list_allocator top level.
module block_pool_free_list_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfl_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam int IN_W          = $bits(t_in_item);
    localparam logic [KIND_W-1:0] KIND_UNDEFINED = 2'd3;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    t_in_item            i_in        = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_out_item           o_out;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Predicted allocator state and configuration
    logic [BLK_W-1:0]    link_mem [POOL_BLOCKS];
    int                  free_hd  = 0;
    int                  free_tl  = 0;
    int                  free_cnt = 0;
    int                  dev_hd   [NUM_DEVICES] = '{default: 0};
    int                  dev_tl   [NUM_DEVICES] = '{default: 0};
    int                  dev_cnt  [NUM_DEVICES] = '{default: 0};
    logic [BSL_W-1:0]    cfg_bsl  = BSL_RESET;
    logic [GRAN_W-1:0]   cfg_gran = GRAN_RESET;

    t_out_item           moves_due [$];
    int                  fail_count  = 0;
    int                  cycle_count = 0;
    int                  idle_pct    = 37;
    int                  out_hold    = 0;

    block_pool_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic void flag_error(input string msg);
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function automatic t_in_item make_req(input logic [KIND_W-1:0] kind, input int dev,
                                          input int cnt);
        t_in_item it;
        it.kind        = kind;
        it.device_id   = DEV_W'(dev);
        it.block_count = BCNT_W'(cnt);
        return it;
    endfunction

    function automatic t_out_item ending(input logic st, input logic [DEV_W-1:0] dev);
        t_out_item r;
        r               = '0;
        r.status        = st;
        r.device_id_res = dev;
        r.free_count    = FREE_W'(free_cnt);
        r.last          = 1'b1;
        return r;
    endfunction

    // Work out every block move that one request causes and queue the results.
    function automatic void predict_block_moves(input t_in_item it);
        int        n;
        int        cnt;
        int        blk;
        int        d;
        logic [63:0] wide_addr;
        t_out_item r;
        d = int'(it.device_id);
        if (it.kind == KIND_INIT) begin
            n = POOL_BLOCKS >> cfg_gran;
            for (int k = 0; k < NUM_DEVICES; k++) begin
                dev_hd[k]  = 0;
                dev_tl[k]  = 0;
                dev_cnt[k] = 0;
            end
            for (int k = 0; k + 1 < n; k++) link_mem[k] = BLK_W'(k + 1);
            free_hd  = 0;
            free_tl  = n - 1;
            free_cnt = n;
            moves_due.push_back(ending(ST_OK, '0));
            return;
        end
        if (it.kind != KIND_ALLOC && it.kind != KIND_RELEASE) begin
            moves_due.push_back(ending(ST_ERR, it.device_id));
            return;
        end
        cnt = (it.block_count > MAX_MOVES) ? MAX_MOVES : int'(it.block_count);
        if (cnt == 0) begin
            moves_due.push_back(ending(ST_OK, it.device_id));
            return;
        end
        for (int i = 0; i < cnt; i++) begin
            r = '0;
            if (it.kind == KIND_ALLOC) begin
                if (free_cnt == 0) begin
                    moves_due.push_back(ending(ST_ERR, it.device_id));
                    return;
                end
                blk      = free_hd;
                free_cnt = free_cnt - 1;
                if (free_cnt != 0) free_hd = int'(link_mem[blk]);
                if (dev_cnt[d] == 0) dev_hd[d] = blk;
                else link_mem[dev_tl[d]] = BLK_W'(blk);
                dev_tl[d]  = blk;
                dev_cnt[d] = dev_cnt[d] + 1;
                r.slot     = SLOT_W'(dev_cnt[d] - 1);
            end else begin
                if (dev_cnt[d] == 0) begin
                    moves_due.push_back(ending(ST_ERR, it.device_id));
                    return;
                end
                blk        = dev_hd[d];
                dev_cnt[d] = dev_cnt[d] - 1;
                if (dev_cnt[d] != 0) dev_hd[d] = int'(link_mem[blk]);
                if (free_cnt == 0) free_hd = blk;
                else link_mem[free_tl] = BLK_W'(blk);
                free_tl  = blk;
                free_cnt = free_cnt + 1;
                r.slot   = SLOT_W'(dev_cnt[d]);
            end
            wide_addr       = 64'(blk) << cfg_bsl;
            r.status        = ST_OK;
            r.device_id_res = it.device_id;
            r.block_addr    = wide_addr[ADDR_W-1:0];
            r.free_count    = FREE_W'(free_cnt);
            r.last          = (i + 1 == cnt);
            moves_due.push_back(r);
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (moves_due.size() == 0) begin
                flag_error($sformatf("unexpected result: %p", o_out));
            end else begin
                want = moves_due.pop_front();
                if (o_out.status !== want.status || o_out.device_id_res !== want.device_id_res
                    || o_out.slot !== want.slot || o_out.block_addr !== want.block_addr
                    || o_out.free_count !== want.free_count || o_out.last !== want.last) begin
                    flag_error({
                        $sformatf("mismatch: want st=%0d dev=%0d slot=%0d addr=%h ",
                                  want.status, want.device_id_res, want.slot,
                                  want.block_addr),
                        $sformatf("free=%0d last=%0d, got st=%0d dev=%0d slot=%0d ",
                                  want.free_count, want.last, o_out.status,
                                  o_out.device_id_res, o_out.slot),
                        $sformatf("addr=%h free=%0d last=%0d",
                                  o_out.block_addr, o_out.free_count, o_out.last)});
                end
            end
        end
    end

    // Result receiver: random stalls, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            out_hold = out_hold - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < idle_pct);
        end
    end

    task automatic send_item(input t_in_item it);
        logic [IN_W-1:0] noise;
        while ($urandom_range(99) < idle_pct) begin
            noise = IN_W'($urandom);
            i_in_valid <= 1'b0;
            i_in       <= noise;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_block_moves(it);
        @(negedge i_clk);
    endtask

    // Drop valid, drain all results, then let the block go idle
    task automatic settle();
        i_in_valid <= 1'b0;
        while (moves_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic read_reg_check(input logic idx);
        logic [PDATA_W-1:0] want;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        want = (idx == REG_BLOCK_SIZE) ? PDATA_W'(cfg_bsl) : PDATA_W'(cfg_gran);
        if (prdata !== want)
            flag_error($sformatf("register %0d reads %h, want %h", idx, prdata, want));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_BLOCK_SIZE) cfg_bsl = value[BSL_W-1:0];
        else cfg_gran = value[GRAN_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        read_reg_check(idx);
    endtask

    function automatic t_in_item random_request(input int alloc_pct);
        int pick;
        int cnt;
        pick = $urandom_range(99);
        cnt  = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(MAX_MOVES, 1);
        if (pick < 3)
            return make_req(KIND_INIT, $urandom_range(NUM_DEVICES - 1), cnt);
        if (pick < 7)
            return make_req(KIND_UNDEFINED, $urandom_range(NUM_DEVICES - 1), cnt);
        if (pick < 7 + (93 * alloc_pct) / 100)
            return make_req(KIND_ALLOC, $urandom_range(NUM_DEVICES - 1), cnt);
        return make_req(KIND_RELEASE, $urandom_range(NUM_DEVICES - 1), cnt);
    endfunction

    task automatic run_phase(input int bsl, input int gran, input int n_items,
                             input int alloc_pct, input int hold_cycles);
        write_reg(REG_BLOCK_SIZE, PDATA_W'(bsl));
        write_reg(REG_GRANULARITY, PDATA_W'(gran));
        send_item(make_req(KIND_INIT, 0, 0));
        // hold results while requests keep coming so the input backs up
        if (hold_cycles > 0) out_hold = hold_cycles;
        repeat (n_items) send_item(random_request(alloc_pct));
        settle();
    endtask

    task automatic test_register_reset();
        read_reg_check(REG_BLOCK_SIZE);
        read_reg_check(REG_GRANULARITY);
    endtask

    // Pool never initialized: every move hits an empty source
    task automatic test_empty_pool();
        send_item(make_req(KIND_ALLOC, 3, 5));
        send_item(make_req(KIND_RELEASE, 0, 1));
        send_item(make_req(KIND_ALLOC, 15, 0));
        send_item(make_req(KIND_UNDEFINED, 10, 31));
        settle();
    endtask

    task automatic test_basic_moves();
        write_reg(REG_BLOCK_SIZE, 32'd20);
        write_reg(REG_GRANULARITY, 32'd3);
        send_item(make_req(KIND_INIT, 5, 3));
        send_item(make_req(KIND_ALLOC, 0, 16));
        send_item(make_req(KIND_ALLOC, 15, 31));
        send_item(make_req(KIND_RELEASE, 0, 5));
        send_item(make_req(KIND_RELEASE, 15, 16));
        send_item(make_req(KIND_ALLOC, 9, 0));
        send_item(make_req(KIND_UNDEFINED, 6, 7));
        send_item(make_req(KIND_ALLOC, 0, 1));
        settle();
    endtask

    // Smallest pool: drain it, then run allocate and release dry mid-item
    task automatic test_exhaust_pool();
        write_reg(REG_BLOCK_SIZE, 32'd40);
        send_item(make_req(KIND_INIT, 0, 0));
        for (int d = 0; d < 7; d++) send_item(make_req(KIND_ALLOC, d, 16));
        send_item(make_req(KIND_ALLOC, 7, 10));
        send_item(make_req(KIND_ALLOC, 8, 16));
        send_item(make_req(KIND_RELEASE, 8, 16));
        send_item(make_req(KIND_RELEASE, 7, 31));
        settle();
    endtask

    // Small pool so the init sweep ends well inside the hold-off
    task automatic test_backpressure();
        run_phase(20, 3, 30, 55, 400);
    endtask

    task automatic test_random_traffic();
        run_phase($urandom_range(40, 20), 0, 70, 55, 0);
        run_phase(63, 2, 70, 60, 0);
        run_phase(0, 1, 70, 50, 0);
        run_phase(47, 3, 70, 60, 0);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        run_phase($urandom_range(40, 20), $urandom_range(3), 40, 55, 0);
        idle_pct = 37;
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_register_reset();
        test_empty_pool();
        test_basic_moves();
        test_exhaust_pool();
        test_backpressure();
        test_random_traffic();
        test_no_idle();
        settle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
